### rtl/core/ambient_light_lux_calculation_assert.svh
// Assertion macros for the lux calculation top level.
// Needs nothing else; take it in with `include.
`ifndef AMBIENT_LIGHT_LUX_CALCULATION_ASSERT_SVH
`define AMBIENT_LIGHT_LUX_CALCULATION_ASSERT_SVH

// Same-cycle implication, checked outside reset
`define ALC_ASSERT_NOW(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("lux calc check failed");

// Next-cycle implication, checked outside reset
`define ALC_ASSERT_NEXT(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("lux calc check failed");

`endif

### rtl/core/alc_pkg.sv
// Package for the lux calculation: widths, scale constants, segment table.
// Used by every module of the block; depends on nothing.
package alc_pkg;

    localparam int CNT_W       = 16;             // raw photodiode count
    localparam int SCALE_W     = 19;
    localparam logic [SCALE_W-1:0] SCALE = 19'h75170;  // 13 ms factor, 0x7517 << 4
    localparam int PROD_W      = CNT_W + SCALE_W;
    localparam int CH_SHIFT    = 10;
    localparam int CH_W        = PROD_W - CH_SHIFT; // scaled channel, 25 bits
    localparam int RATIO_SHIFT = 9;
    // quotient bits kept by the divider; larger quotients saturate
    localparam int Q_W         = RATIO_SHIFT + 3;
    localparam int NUM_W       = CH_W + RATIO_SHIFT + 1;
    localparam int SEG_N       = 8;
    localparam int SEG_W       = 3;
    localparam int COEF_W      = 10;
    localparam int MUL_W       = CH_W + COEF_W;
    localparam int LUX_SHIFT   = 14;
    localparam int LUX_W       = 21;

    // Scaled channel pair
    typedef struct packed {
        logic [CH_W-1:0] c0;
        logic [CH_W-1:0] c1;
    } alc_chan_t;

    // Divider stage contents
    typedef struct packed {
        logic [CH_W-1:0] c0;
        logic [CH_W-1:0] c1;
        logic [CH_W-1:0] rem;
        logic [Q_W-1:0]  q;
        logic            sat;
    } alc_div_t;

    // Upper ratio bound of segments 0..6 (segment 7 is open ended)
    function automatic logic [Q_W-1:0] seg_limit(input logic [SEG_W-1:0] sel);
        logic [Q_W-1:0] lim;
        unique case (sel)
            3'd0:    lim = 12'h040;
            3'd1:    lim = 12'h080;
            3'd2:    lim = 12'h0c0;
            3'd3:    lim = 12'h100;
            3'd4:    lim = 12'h138;
            3'd5:    lim = 12'h19a;
            3'd6:    lim = 12'h29a;
            3'd7:    lim = 12'hfff;
        endcase
        return lim;
    endfunction

    // Segment intercept
    function automatic logic [COEF_W-1:0] seg_b(input logic [SEG_W-1:0] sel);
        logic [COEF_W-1:0] b;
        unique case (sel)
            3'd0:    b = 10'h1f2;
            3'd1:    b = 10'h214;
            3'd2:    b = 10'h23f;
            3'd3:    b = 10'h270;
            3'd4:    b = 10'h16f;
            3'd5:    b = 10'h0d2;
            3'd6:    b = 10'h018;
            3'd7:    b = 10'h000;
        endcase
        return b;
    endfunction

    // Segment slope
    function automatic logic [COEF_W-1:0] seg_m(input logic [SEG_W-1:0] sel);
        logic [COEF_W-1:0] m;
        unique case (sel)
            3'd0:    m = 10'h1be;
            3'd1:    m = 10'h2d1;
            3'd2:    m = 10'h37b;
            3'd3:    m = 10'h3fe;
            3'd4:    m = 10'h1fc;
            3'd5:    m = 10'h0fb;
            3'd6:    m = 10'h012;
            3'd7:    m = 10'h000;
        endcase
        return m;
    endfunction

endpackage

### rtl/core/alc_front.sv
// Input stage: scales both raw counts by the integration factor.
// Depends on alc_pkg.
module alc_front (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    en,
    input  logic                    in_valid,
    input  logic [alc_pkg::CNT_W-1:0] ch0,
    input  logic [alc_pkg::CNT_W-1:0] ch1,
    output logic                    out_valid,
    output alc_pkg::alc_chan_t      out_chan
);

    logic [alc_pkg::PROD_W-1:0] prod0;
    logic [alc_pkg::PROD_W-1:0] prod1;
    logic                       valid_reg;
    alc_pkg::alc_chan_t         chan_reg;
    alc_pkg::alc_chan_t         chan_next;

    // count * scale, drop the low fraction bits
    always_comb begin
        prod0 = alc_pkg::PROD_W'(ch0) * alc_pkg::PROD_W'(alc_pkg::SCALE);
        prod1 = alc_pkg::PROD_W'(ch1) * alc_pkg::PROD_W'(alc_pkg::SCALE);
        chan_next.c0 = prod0[alc_pkg::PROD_W-1:alc_pkg::CH_SHIFT];
        chan_next.c1 = prod1[alc_pkg::PROD_W-1:alc_pkg::CH_SHIFT];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            chan_reg <= chan_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_chan  = chan_reg;

endmodule

### rtl/core/alc_div.sv
// Pipelined restoring divider for the ratio (c1 << 10) / c0, one quotient
// bit per stage, saturating when the quotient needs more than Q_W bits.
// Depends on alc_pkg.
module alc_div (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               en,
    input  logic               in_valid,
    input  alc_pkg::alc_chan_t in_chan,
    output logic               out_valid,
    output alc_pkg::alc_div_t  out_div
);

    localparam int NSTG = alc_pkg::Q_W + 1;

    logic              valid_reg [NSTG];
    alc_pkg::alc_div_t stg_reg   [NSTG];
    alc_pkg::alc_div_t init_next;

    // Setup stage: overflow check and first partial remainder (numerator >> Q_W).
    // A zero divisor also saturates, which lands in the zero-lux segment.
    always_comb begin
        init_next.c0  = in_chan.c0;
        init_next.c1  = in_chan.c1;
        init_next.sat = ({in_chan.c1, (alc_pkg::RATIO_SHIFT + 1)'(0)} >>
                         alc_pkg::Q_W) >= alc_pkg::NUM_W'(in_chan.c0);
        init_next.rem = alc_pkg::CH_W'({in_chan.c1, (alc_pkg::RATIO_SHIFT + 1)'(0)}
                         >> alc_pkg::Q_W);
        init_next.q   = '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg[0] <= 1'b0;
        end else if (en) begin
            valid_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            stg_reg[0] <= init_next;
        end
    end

    // One compare-subtract per stage
    for (genvar k = 0; k < alc_pkg::Q_W; k++) begin : g_step
        logic [alc_pkg::NUM_W-1:0] num;
        logic [alc_pkg::CH_W:0]    trial;
        logic [alc_pkg::CH_W:0]    diff;
        alc_pkg::alc_div_t         step_next;

        always_comb begin
            num   = {stg_reg[k].c1, (alc_pkg::RATIO_SHIFT + 1)'(0)};
            trial = {stg_reg[k].rem, num[alc_pkg::Q_W-1-k]};
            diff  = trial - {1'b0, stg_reg[k].c0};
            step_next = stg_reg[k];
            if (trial >= {1'b0, stg_reg[k].c0}) begin
                step_next.rem = diff[alc_pkg::CH_W-1:0];
                step_next.q   = {stg_reg[k].q[alc_pkg::Q_W-2:0], 1'b1};
            end else begin
                step_next.rem = trial[alc_pkg::CH_W-1:0];
                step_next.q   = {stg_reg[k].q[alc_pkg::Q_W-2:0], 1'b0};
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[k+1] <= 1'b0;
            end else if (en) begin
                valid_reg[k+1] <= valid_reg[k];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                stg_reg[k+1] <= step_next;
            end
        end
    end

    assign out_valid = valid_reg[NSTG-1];
    assign out_div   = stg_reg[NSTG-1];

endmodule

### rtl/core/alc_back.sv
// Back end: segment select from the rounded ratio, the two coefficient
// products, then clamp, round and shift to whole lux. Depends on alc_pkg.
module alc_back (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      en,
    input  logic                      in_valid,
    input  alc_pkg::alc_div_t         in_div,
    output logic                      out_valid,
    output logic [alc_pkg::LUX_W-1:0] out_lux
);

    typedef struct packed {
        logic [alc_pkg::CH_W-1:0]   c0;
        logic [alc_pkg::CH_W-1:0]   c1;
        logic [alc_pkg::COEF_W-1:0] b;
        logic [alc_pkg::COEF_W-1:0] m;
    } coef_t;

    typedef struct packed {
        logic [alc_pkg::MUL_W-1:0] pos;
        logic [alc_pkg::MUL_W-1:0] neg;
    } prod_t;

    logic [alc_pkg::Q_W:0]      ratio_sum;
    logic [alc_pkg::Q_W-1:0]    ratio;
    logic [alc_pkg::SEG_W-1:0]  sel;
    coef_t                      coef_next;
    coef_t                      coef_reg;
    prod_t                      prod_next;
    prod_t                      prod_reg;
    logic [alc_pkg::MUL_W:0]    acc;
    logic [alc_pkg::LUX_W-1:0]  lux_next;
    logic [alc_pkg::LUX_W-1:0]  lux_reg;
    logic [2:0]                 valid_reg;

    // Stage 1: round the ratio, count breakpoints below it
    always_comb begin
        ratio_sum = {1'b0, in_div.q} + 1'b1;
        ratio     = ratio_sum[alc_pkg::Q_W:1];
        sel       = '0;
        for (int i = 0; i < alc_pkg::SEG_N - 1; i++) begin
            if (ratio > alc_pkg::seg_limit(alc_pkg::SEG_W'(i))) begin
                sel = sel + 1'b1;
            end
        end
        if (in_div.sat) begin
            sel = alc_pkg::SEG_W'(alc_pkg::SEG_N - 1);
        end
        coef_next.c0 = in_div.c0;
        coef_next.c1 = in_div.c1;
        coef_next.b  = alc_pkg::seg_b(sel);
        coef_next.m  = alc_pkg::seg_m(sel);
    end

    // Stage 2: b*ch0 and m*ch1
    always_comb begin
        prod_next.pos = alc_pkg::MUL_W'(coef_reg.c0) * alc_pkg::MUL_W'(coef_reg.b);
        prod_next.neg = alc_pkg::MUL_W'(coef_reg.c1) * alc_pkg::MUL_W'(coef_reg.m);
    end

    // Stage 3: clamp at zero, add half, shift
    always_comb begin
        acc = '0;
        if (prod_reg.pos > prod_reg.neg) begin
            acc = {1'b0, prod_reg.pos - prod_reg.neg};
        end
        acc      = acc + (alc_pkg::MUL_W + 1)'(1 << (alc_pkg::LUX_SHIFT - 1));
        lux_next = acc[alc_pkg::LUX_SHIFT +: alc_pkg::LUX_W];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (en) begin
            valid_reg <= {valid_reg[1:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            coef_reg <= coef_next;
            prod_reg <= prod_next;
            lux_reg  <= lux_next;
        end
    end

    assign out_valid = valid_reg[2];
    assign out_lux   = lux_reg;

endmodule

### rtl/core/alc_skid.sv
// Output register with a skid word; pipeline enable is the registered
// "skid empty" flag. Depends on alc_pkg.
module alc_skid (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      in_valid,
    input  logic [alc_pkg::LUX_W-1:0] in_lux,
    output logic                      in_ready,
    output logic                      out_valid,
    output logic [alc_pkg::LUX_W-1:0] out_lux,
    input  logic                      out_ready
);

    logic                      out_valid_reg;
    logic [alc_pkg::LUX_W-1:0] out_lux_reg;
    logic                      skid_valid_reg;
    logic [alc_pkg::LUX_W-1:0] skid_lux_reg;
    logic                      take;

    assign take = in_valid && !skid_valid_reg;

    // control: output slot, then skid slot when the output stalls
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (out_ready || !out_valid_reg) begin
            out_valid_reg  <= skid_valid_reg || take;
            skid_valid_reg <= 1'b0;
        end else if (take) begin
            skid_valid_reg <= 1'b1;
        end
    end

    // data
    always_ff @(posedge aclk) begin
        if (out_ready || !out_valid_reg) begin
            out_lux_reg <= skid_valid_reg ? skid_lux_reg : in_lux;
        end else if (take) begin
            skid_lux_reg <= in_lux;
        end
    end

    assign in_ready  = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_lux   = out_lux_reg;

endmodule

### rtl/core/ambient_light_lux_calculation.sv
// Lux from a broadband and an infrared photodiode count (13 ms, 1x gain).
// One word in per cycle while s_tready is high, one lux word out per word
// in, in order; a word accepted on s_tready reaches m_tvalid through 18
// register stages: one scaling stage, a 13-stage divider (setup plus one
// quotient bit per stage) for the channel ratio, three stages for segment
// select, coefficient products and rounding, and the output register. The
// pipeline advances whenever its skid word is empty, so s_tready falls only
// in the cycle after the output has stalled with a word behind it. No reset
// sweep; words may be sent right after reset.
// Depends on alc_pkg, alc_front, alc_div, alc_back, alc_skid.
`include "ambient_light_lux_calculation_assert.svh"

module ambient_light_lux_calculation (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,  // [15:0] broadband_count, [31:16] infrared_count
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata   // [20:0] lux, [23:21] zero
);

    logic                      en;
    logic                      front_valid;
    alc_pkg::alc_chan_t        front_chan;
    logic                      div_valid;
    alc_pkg::alc_div_t         div_out;
    logic                      back_valid;
    logic [alc_pkg::LUX_W-1:0] back_lux;
    logic [alc_pkg::LUX_W-1:0] lux;

    assign s_tready = en;

    alc_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_tvalid),
        .ch0       (s_tdata[15:0]),
        .ch1       (s_tdata[31:16]),
        .out_valid (front_valid),
        .out_chan  (front_chan)
    );

    alc_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (front_valid),
        .in_chan   (front_chan),
        .out_valid (div_valid),
        .out_div   (div_out)
    );

    alc_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (div_valid),
        .in_div    (div_out),
        .out_valid (back_valid),
        .out_lux   (back_lux)
    );

    alc_skid u_skid (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (back_valid),
        .in_lux    (back_lux),
        .in_ready  (en),
        .out_valid (m_tvalid),
        .out_lux   (lux),
        .out_ready (m_tready)
    );

    assign m_tdata = {3'b000, lux};

    // A held skid word means the output slot is full
    `ALC_ASSERT_NOW(a_stall_has_output, aclk, aresetn, !s_tready, m_tvalid)
    // A stalled output with a word arriving must park it and drop ready
    `ALC_ASSERT_NEXT(a_skid_catches, aclk, aresetn,
        m_tvalid && !m_tready && back_valid && s_tready, !s_tready)

endmodule

### tb/tb_ambient_light_lux_calculation.sv
// Self-checking testbench for ambient_light_lux_calculation.
// Drives count pairs on the input stream and checks every lux word against
// an in-bench predictor. Needs only the RTL of the block.
`timescale 1ns / 100ps

module tb_ambient_light_lux_calculation;

    localparam int        HALF_PERIOD  = 5;
    localparam int        RESET_CYCLES = 12;
    localparam int        DRAIN_CYCLES = 40;   // more than the 18-stage pipeline depth
    localparam bit [63:0] ITIME_SCALE  = 64'h75170;  // 13 ms factor at 1x gain
    localparam int        CHAN_SHIFT   = 10;
    localparam int        FRAC_BITS    = 9;
    localparam int        OUT_SHIFT    = 14;

    // Upper ratio edge of segments 0..6; segment 7 takes everything above
    localparam bit [15:0] RATIO_EDGE [7] = '{
        16'h0040, 16'h0080, 16'h00c0, 16'h0100, 16'h0138, 16'h019a, 16'h029a
    };
    localparam bit [9:0] INTERCEPT [8] = '{
        10'h1f2, 10'h214, 10'h23f, 10'h270, 10'h16f, 10'h0d2, 10'h018, 10'h000
    };
    localparam bit [9:0] SLOPE [8] = '{
        10'h1be, 10'h2d1, 10'h37b, 10'h3fe, 10'h1fc, 10'h0fb, 10'h012, 10'h000
    };

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;   // [15:0] broadband_count, [31:16] infrared_count
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;   // [20:0] lux, [23:21] zero

    bit [20:0] pending_lux [$];
    int        fail_count;
    int        rx_hold_req;   // long receiver hold, in cycles
    bit        rx_steady;     // receiver starts no new stalls while set

    ambient_light_lux_calculation dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial aclk = 1'b0;
    always #HALF_PERIOD aclk = ~aclk;

    // Lux for one count pair, full width throughout
    function automatic bit [20:0] predict_lux(input bit [15:0] bb, input bit [15:0] ir);
        bit [63:0] c0;
        bit [63:0] c1;
        bit [63:0] quot;
        bit [63:0] ratio;
        bit [63:0] pos;
        bit [63:0] neg;
        bit [63:0] acc;
        int        seg;
        c0   = ({48'd0, bb} * ITIME_SCALE) >> CHAN_SHIFT;
        c1   = ({48'd0, ir} * ITIME_SCALE) >> CHAN_SHIFT;
        quot = (c0 == 0) ? 64'd0 : (c1 << (FRAC_BITS + 1)) / c0;
        ratio = (quot + 64'd1) >> 1;
        seg = 7;
        for (int i = 6; i >= 0; i--)
            if (ratio <= {48'd0, RATIO_EDGE[i]})
                seg = i;
        pos = c0 * {54'd0, INTERCEPT[seg]};
        neg = c1 * {54'd0, SLOPE[seg]};
        acc = (pos > neg) ? pos - neg : 64'd0;
        acc = acc + (64'd1 << (OUT_SHIFT - 1));
        return acc[OUT_SHIFT +: 21];
    endfunction

    // Idle length: mostly short, now and then long
    function automatic int idle_len();
        if ($urandom_range(0, 99) < 85)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Count pair biased toward every ratio segment
    task automatic pick_counts(output bit [15:0] bb, output bit [15:0] ir);
        int unsigned kind;
        int unsigned frac;
        bit [31:0]   scaled;
        kind = $urandom_range(0, 9);
        bb   = 16'($urandom_range(0, 16'hffff));
        ir   = 16'($urandom_range(0, 16'hffff));
        if (kind >= 3 && kind <= 7) begin
            // ir as a fraction of bb, ratio 0..~1.4
            frac   = $urandom_range(0, 720);
            scaled = (bb * frac) >> FRAC_BITS;
            ir     = (scaled > 32'hffff) ? 16'hffff : scaled[15:0];
        end else if (kind == 8) begin
            bb = 16'($urandom_range(0, 15));
            ir = 16'($urandom_range(0, 15));
        end else if (kind == 9) begin
            bb = $urandom_range(0, 1) ? 16'hffff : 16'h0000;
            ir = $urandom_range(0, 1) ? 16'hffff : 16'($urandom_range(0, 16'hffff));
        end
    endtask

    // Offer one word after an optional gap; hold until accepted
    task automatic send_word(input bit [15:0] bb, input bit [15:0] ir, input int gap);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {ir, bb};
        do @(posedge aclk); while (!s_tready);
        pending_lux.push_back(predict_lux(bb, ir));
    endtask

    // Stop offering, then wait until every predicted word is back
    task automatic wait_all_lux();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_lux.size() != 0) @(posedge aclk);
    endtask

    // Extremes, tiny counts, ir above bb, and both sides of every segment edge
    task automatic test_directed();
        send_word(16'h0000, 16'h0000, 0);
        send_word(16'hffff, 16'h0000, 0);
        send_word(16'h0000, 16'hffff, 0);
        send_word(16'hffff, 16'hffff, 0);
        send_word(16'h0001, 16'h0000, 1);
        send_word(16'h0000, 16'h0001, 0);
        send_word(16'h0003, 16'h0003, 0);
        send_word(16'd100,  16'd200,  2);
        // bb = 4096 makes the ratio exactly ir/8; edge and one step above
        for (int i = 0; i < 7; i++) begin
            send_word(16'd4096, 16'(RATIO_EDGE[i] * 8), 0);
            send_word(16'd4096, 16'(RATIO_EDGE[i] * 8 + 8), 0);
        end
        wait_all_lux();
    endtask

    // Random content with random gaps on both sides
    task automatic test_random_flow(input int count);
        bit [15:0] bb;
        bit [15:0] ir;
        for (int n = 0; n < count; n++) begin
            pick_counts(bb, ir);
            send_word(bb, ir, $urandom_range(0, 1) ? 0 : idle_len());
        end
    endtask

    // Full rate, no idling on either side
    task automatic test_full_rate(input int count);
        bit [15:0] bb;
        bit [15:0] ir;
        wait_all_lux();
        rx_steady = 1'b1;
        for (int n = 0; n < count; n++) begin
            pick_counts(bb, ir);
            send_word(bb, ir, 0);
        end
        wait_all_lux();
        rx_steady = 1'b0;
    endtask

    // Receiver holds off long enough that the pipeline fills and s_tready drops
    task automatic test_backpressure(input int count);
        bit [15:0] bb;
        bit [15:0] ir;
        rx_hold_req = 300;
        for (int n = 0; n < count; n++) begin
            pick_counts(bb, ir);
            send_word(bb, ir, 0);
        end
        // sender rests until every lux word is back
        wait_all_lux();
    endtask

    // Receiver: random stalls, long hold on request
    initial begin
        int stall_left;
        int hold_left;
        stall_left = 0;
        hold_left  = 0;
        m_tready   = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            @(posedge aclk);
            if (rx_hold_req > 0) begin
                hold_left   = rx_hold_req;
                rx_hold_req = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                if (!rx_steady && $urandom_range(0, 99) < 25)
                    stall_left = idle_len();
            end
        end
    end

    // Compare each accepted lux word with the oldest prediction
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_lux.size() == 0) begin
                $display("%0t: lux word 0x%06h with none expected", $time, m_tdata);
                fail_count++;
            end else begin
                bit [20:0] want;
                want = pending_lux.pop_front();
                if (m_tdata !== {3'b000, want}) begin
                    $display("%0t: lux mismatch: expected %0d (0x%06h), got %0d (0x%06h)",
                             $time, want, {3'b000, want}, m_tdata[20:0], m_tdata);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog
    initial begin
        #10ms;
        $display("tb: failure");
        $finish;
    end

    initial begin
        fail_count  = 0;
        rx_hold_req = 0;
        rx_steady   = 1'b0;
        aresetn     = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = 32'd0;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        test_directed();
        test_random_flow(700);
        test_backpressure(120);
        test_random_flow(580);
        test_full_rate(200);

        wait_all_lux();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
